>>> hw/rtl/button_action_pulse_sequencer_top_assert.svh
// Assertion macros for the key action pulse sequencer.
`ifndef BUTTON_ACTION_PULSE_SEQUENCER_TOP_ASSERT_SVH
`define BUTTON_ACTION_PULSE_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH

// Clocked check that is switched off while reset is held.
`define BAPSEQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bapseq assertion failed");

// Clocked check of a condition that must never be true outside reset.
`define BAPSEQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    `BAPSEQ_ASSERT(label, clk, rst_n, !(cond))

`else

`define BAPSEQ_ASSERT(label, clk, rst_n, prop)
`define BAPSEQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/bapseq_pkg.sv
// Shared types, codes and reset values of the key action pulse sequencer.
`default_nettype none

package bapseq_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned SEL_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [DELAY_W-1:0] t_delay;
    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [ACT_W-1:0]   t_act;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [SEL_W-1:0]   t_sel;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Commands.
    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_ADD  = 2'd1;
    localparam t_cmd CMD_STOP = 2'd2;

    // Actions.
    localparam t_act ACT_IDLE    = 3'd0;
    localparam t_act ACT_PLAY    = 3'd1;
    localparam t_act ACT_NEXT    = 3'd2;
    localparam t_act ACT_PREV    = 3'd3;
    localparam t_act ACT_PWR_ON  = 3'd4;
    localparam t_act ACT_PWR_OFF = 3'd5;

    // Key line selects.
    localparam t_sel SEL_PLAY = 2'd0;
    localparam t_sel SEL_NEXT = 2'd1;
    localparam t_sel SEL_PREV = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_IMMEDIATE_DUE = 2'd0;
    localparam t_cfg_idx CFG_MUTE_DELAY    = 2'd1;
    localparam t_cfg_idx CFG_REPEAT_GAP    = 2'd2;
    localparam t_cfg_idx CFG_PULSE_LENGTH  = 2'd3;

    // Configuration reset values.
    localparam t_time  RST_IMMEDIATE_DUE = 32'd0;
    localparam t_delay RST_MUTE_DELAY    = 16'd1000;
    localparam t_delay RST_REPEAT_GAP    = 16'd300;
    localparam t_delay RST_PULSE_LENGTH  = 16'd100;

    localparam t_count COUNT_MAX = '1;

endpackage

`default_nettype wire

>>> hw/rtl/button_action_pulse_sequencer_top.sv
// Top level of the key action pulse sequencer: input stage, step logic and result register.
//
//   channel   direction  handshake                     payload
//   input     in         i_in_valid / o_in_stall       i_command, i_action
//   result    out        o_out_valid / i_out_stall     o_play_line, o_next_line, o_prev_line,
//                                                      o_power_line, o_waiting_action,
//                                                      o_waiting_count, o_pulse_dropped
//   config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// Every item yields exactly one result item. An accepted item is held in the input
// register; the step logic, a few 32-bit adds and compares, then loads the result register
// from it, one item per cycle while the result side does not stall.
// Reset is synchronous and active low; it clears the state and loads the register defaults.
// A stall on the result side holds the result register; the input register then keeps its
// item and raises o_in_stall, so nothing is lost while the result side waits.
`default_nettype none

`include "button_action_pulse_sequencer_top_assert.svh"

module button_action_pulse_sequencer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [bapseq_pkg::CMD_W-1:0]  i_command,
    input  wire logic [bapseq_pkg::ACT_W-1:0]  i_action,

    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_play_line,
    output logic                             o_next_line,
    output logic                             o_prev_line,
    output logic                             o_power_line,
    output logic [bapseq_pkg::ACT_W-1:0]     o_waiting_action,
    output logic [bapseq_pkg::COUNT_W-1:0]   o_waiting_count,
    output logic                             o_pulse_dropped,

    input  wire logic                        i_cfg_we,
    input  wire logic [bapseq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bapseq_pkg::TIME_W-1:0]    i_cfg_data
);

    // Configuration registers.
    bapseq_pkg::t_time  r_immediate_due;
    bapseq_pkg::t_delay r_mute_delay;
    bapseq_pkg::t_delay r_repeat_gap;
    bapseq_pkg::t_delay r_pulse_length;

    // Input stage.
    logic               r_in_valid;
    bapseq_pkg::t_cmd   r_in_cmd;
    bapseq_pkg::t_act   r_in_act;

    // Sequencer state. A pulse end time of zero means that no pulse is active.
    bapseq_pkg::t_time  r_now,       n_now;
    bapseq_pkg::t_act   r_held_action, n_held_action;
    bapseq_pkg::t_count r_held_count,  n_held_count;
    bapseq_pkg::t_time  r_due,       n_due;
    bapseq_pkg::t_time  r_pulse_end, n_pulse_end;
    bapseq_pkg::t_sel   r_pulse_sel, n_pulse_sel;
    logic               r_power,     n_power;
    logic               n_dropped;

    // Result register.
    logic               r_out_valid;

    // Step helpers.
    bapseq_pkg::t_time  now_inc;
    bapseq_pkg::t_time  start_end;
    bapseq_pkg::t_count count_after_fire;
    logic               out_free;
    logic               step_en;
    logic               pulse_on;

    // The result register can load when it is empty or its item leaves in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_en    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // The clock advances before anything else in a tick.
    assign now_inc = r_now + bapseq_pkg::TIME_W'(1);

    // A pulse whose end would wrap to zero is held at one so it still reads as active.
    always_comb begin
        start_end = now_inc + {{(bapseq_pkg::TIME_W - bapseq_pkg::DELAY_W){1'b0}}, r_pulse_length};
        if (start_end == '0) begin
            start_end = bapseq_pkg::TIME_W'(1);
        end
    end

    assign count_after_fire = (r_held_count != '0) ? r_held_count - bapseq_pkg::COUNT_W'(1)
                                                   : r_held_count;

    // One step of the sequencer for the item in the input register.
    always_comb begin
        n_now         = r_now;
        n_held_action = r_held_action;
        n_held_count  = r_held_count;
        n_due         = r_due;
        n_pulse_end   = r_pulse_end;
        n_pulse_sel   = r_pulse_sel;
        n_power       = r_power;
        n_dropped     = 1'b0;

        case (r_in_cmd)
            bapseq_pkg::CMD_TICK: begin
                n_now = now_inc;
                // Fire the pending action when its due time is reached.
                if (r_held_action != bapseq_pkg::ACT_IDLE && now_inc >= r_due) begin
                    case (r_held_action) inside
                        bapseq_pkg::ACT_PLAY, bapseq_pkg::ACT_NEXT, bapseq_pkg::ACT_PREV: begin
                            if (r_pulse_end == '0) begin
                                n_pulse_end = start_end;
                                // Play, next and previous map onto selects zero to two.
                                n_pulse_sel = r_held_action[bapseq_pkg::SEL_W-1:0]
                                              - bapseq_pkg::SEL_W'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        bapseq_pkg::ACT_PWR_ON: begin
                            n_power = 1'b1;
                        end
                        bapseq_pkg::ACT_PWR_OFF: begin
                            n_power = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    n_held_count = count_after_fire;
                    if (count_after_fire == '0) begin
                        n_held_action = bapseq_pkg::ACT_IDLE;
                    end else begin
                        n_due = now_inc + {{(bapseq_pkg::TIME_W - bapseq_pkg::DELAY_W){1'b0}},
                                           r_repeat_gap};
                    end
                end
                // The end check sees a pulse that was started in this same tick.
                if (n_pulse_end != '0 && now_inc >= n_pulse_end) begin
                    n_pulse_end = '0;
                end
            end
            bapseq_pkg::CMD_ADD: begin
                if (r_in_act == bapseq_pkg::ACT_IDLE) begin
                    n_held_action = bapseq_pkg::ACT_IDLE;
                    n_held_count  = '0;
                end else if (r_in_act <= bapseq_pkg::ACT_PWR_OFF) begin
                    if (r_in_act == r_held_action) begin
                        if (r_held_count != bapseq_pkg::COUNT_MAX) begin
                            n_held_count = r_held_count + bapseq_pkg::COUNT_W'(1);
                        end
                    end else begin
                        n_held_action = r_in_act;
                        n_held_count  = bapseq_pkg::COUNT_W'(1);
                        if (r_in_act == bapseq_pkg::ACT_NEXT ||
                            r_in_act == bapseq_pkg::ACT_PREV) begin
                            n_due = r_now + {{(bapseq_pkg::TIME_W - bapseq_pkg::DELAY_W){1'b0}},
                                             r_mute_delay};
                        end else begin
                            n_due = r_immediate_due;
                        end
                    end
                end
            end
            bapseq_pkg::CMD_STOP: begin
                // A stop makes the active pulse end at the next tick.
                if (r_pulse_end != '0) begin
                    n_pulse_end = bapseq_pkg::TIME_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign pulse_on = (n_pulse_end != '0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_immediate_due <= bapseq_pkg::RST_IMMEDIATE_DUE;
            r_mute_delay    <= bapseq_pkg::RST_MUTE_DELAY;
            r_repeat_gap    <= bapseq_pkg::RST_REPEAT_GAP;
            r_pulse_length  <= bapseq_pkg::RST_PULSE_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bapseq_pkg::CFG_IMMEDIATE_DUE: r_immediate_due <= i_cfg_data;
                bapseq_pkg::CFG_MUTE_DELAY:    r_mute_delay   <= i_cfg_data[bapseq_pkg::DELAY_W-1:0];
                bapseq_pkg::CFG_REPEAT_GAP:    r_repeat_gap   <= i_cfg_data[bapseq_pkg::DELAY_W-1:0];
                bapseq_pkg::CFG_PULSE_LENGTH:  r_pulse_length <= i_cfg_data[bapseq_pkg::DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_cmd <= i_command;
            r_in_act <= i_action;
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_held_action <= bapseq_pkg::ACT_IDLE;
            r_held_count  <= '0;
            r_due         <= '0;
            r_pulse_end   <= '0;
            r_pulse_sel   <= bapseq_pkg::SEL_PLAY;
            r_power       <= 1'b0;
        end else if (step_en) begin
            r_now         <= n_now;
            r_held_action <= n_held_action;
            r_held_count  <= n_held_count;
            r_due         <= n_due;
            r_pulse_end   <= n_pulse_end;
            r_pulse_sel   <= n_pulse_sel;
            r_power       <= n_power;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload: the state as it stands after the step.
    always_ff @(posedge i_clk) begin
        if (step_en) begin
            o_play_line      <= pulse_on && (n_pulse_sel == bapseq_pkg::SEL_PLAY);
            o_next_line      <= pulse_on && (n_pulse_sel == bapseq_pkg::SEL_NEXT);
            o_prev_line      <= pulse_on && (n_pulse_sel == bapseq_pkg::SEL_PREV);
            o_power_line     <= n_power;
            o_waiting_action <= n_held_action;
            o_waiting_count  <= n_held_count;
            o_pulse_dropped  <= n_dropped;
        end
    end

    assign o_out_valid = r_out_valid;

    // A pending action always has repeats left, and an idle one has none.
    `BAPSEQ_ASSERT(a_held_count_matches, i_clk, i_rst_n, (r_held_action == bapseq_pkg::ACT_IDLE) == (r_held_count == '0))
    // At most one key line is high in any result.
    `BAPSEQ_ASSERT(a_one_key_line, i_clk, i_rst_n, !o_out_valid || $onehot0({o_play_line, o_next_line, o_prev_line}))
    // A stalled item in the input stage stays there unchanged.
    `BAPSEQ_ASSERT(a_in_stage_holds, i_clk, i_rst_n, o_in_stall |=> r_in_valid && $stable(r_in_cmd) && $stable(r_in_act))
    // The clock only moves on a tick.
    `BAPSEQ_ASSERT_NEVER(a_clock_moves_on_tick, i_clk, i_rst_n, step_en && r_in_cmd != bapseq_pkg::CMD_TICK && n_now != r_now)

endmodule

`default_nettype wire
